>>> rtl/core/pwcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcd_pkg
// Shared types, register indexes and helpers of the pixel window contrast
// detector.
// ----------------------------------------------------------------------------
package pwcd_pkg;

    localparam int SUM_W        = 10;
    localparam int COL_W        = 10;
    localparam int ROW_W        = 12;
    localparam int HEIGHT_W     = 13;
    localparam int WIDTH_CFG_W  = 11;
    localparam int THRESH_W     = 10;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int NUM_TAPS     = 8;

    localparam int MAX_HEIGHT      = 4096;
    localparam int MAX_DELTA       = 765;
    localparam int RESET_WIDTH     = 640;
    localparam int RESET_HEIGHT    = 480;
    localparam int RESET_THRESHOLD = 0;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH        = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT       = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CONTRAST_THRESHOLD = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pwcd_in_t;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [SUM_W-1:0]  max_delta;
        logic              needs_resample;
        logic              frame_end;
    } pwcd_out_t;

    // One position moving from the sequencer into the window datapath
    typedef struct packed {
        logic              valid;
        logic              emit;
        logic              last;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic              left_ok;
        logic              right_ok;
        logic              top_ok;
        logic              bot_ok;
        logic [SUM_W-1:0]  sum;
    } pwcd_item_t;

    function automatic logic [SUM_W-1:0] abs_diff(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [SUM_W-1:0] max2(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> rtl/core/pwcd_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcd_line_store
// Two line memories of pixel sums (two rows back, one row back) with a
// registered read port and write-to-read forwarding on the same entry.
// ----------------------------------------------------------------------------
module pwcd_line_store
    import pwcd_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [SUM_W-1:0]         wr_older,
    input  logic [SUM_W-1:0]         wr_newer,
    output logic [SUM_W-1:0]         rd_older,
    output logic [SUM_W-1:0]         rd_newer
);

    logic [SUM_W-1:0] older_mem [DEPTH];
    logic [SUM_W-1:0] newer_mem [DEPTH];

    logic [SUM_W-1:0] older_q_reg;
    logic [SUM_W-1:0] newer_q_reg;
    logic [SUM_W-1:0] fwd_older_reg;
    logic [SUM_W-1:0] fwd_newer_reg;
    logic             fwd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            older_mem[wr_addr] <= wr_older;
            newer_mem[wr_addr] <= wr_newer;
        end
        if (rd_en) begin
            older_q_reg   <= older_mem[rd_addr];
            newer_q_reg   <= newer_mem[rd_addr];
            fwd_older_reg <= wr_older;
            fwd_newer_reg <= wr_newer;
        end
    end

    // A read that meets a write to the same entry sees the old word: take the
    // data being written instead.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_older = fwd_hit_reg ? fwd_older_reg : older_q_reg;
    assign rd_newer = fwd_hit_reg ? fwd_newer_reg : newer_q_reg;

endmodule

>>> rtl/core/pwcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcd_ctrl
// Configuration registers, frame position and pending counters; turns each pixel
// or valid drain transfer into one window position and issues the line store read.
// ----------------------------------------------------------------------------
module pwcd_ctrl
    import pwcd_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [CFG_DATA_W-1:0]        cfg_wr_data,
    input  logic                         advance,
    input  logic                         in_accept,
    input  pwcd_in_t                     in_data,
    output logic                         rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output pwcd_item_t                   item,
    output logic [$clog2(MAX_WIDTH)-1:0] item_addr,
    output logic [THRESH_W-1:0]          threshold
);

    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int PW      = $clog2(MAX_WIDTH + 2);
    localparam int XW      = (WW > WIDTH_CFG_W) ? WW : WIDTH_CFG_W;
    localparam int RESET_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    logic [WW-1:0]       width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic [AW-1:0]       col_reg,  col_next;
    logic [ROW_W-1:0]    row_reg,  row_next;
    logic [PW-1:0]       pend_reg, pend_next;
    pwcd_item_t          item_reg, item_next;
    logic [AW-1:0]       addr_reg;

    logic [WIDTH_CFG_W-1:0] cfg_w;
    logic [XW-1:0]          cfg_w_ext;
    logic [WW-1:0]          width_clamped;
    logic [HEIGHT_W-1:0]    cfg_h;
    logic [HEIGHT_W-1:0]    height_clamped;

    logic                is_pix;
    logic                is_drain;
    logic                at_origin;
    logic                drain_ok;
    logic                go;
    logic [AW-1:0]       w_m1;
    logic [PW-1:0]       w_plus1;
    logic [WW-1:0]       step;
    logic                step_wrap;
    logic [AW-1:0]       x_s;
    logic [HEIGHT_W-1:0] y_s;
    logic                x_zero;
    logic                emit;
    logic [AW-1:0]       qx;
    logic [HEIGHT_W-1:0] qy;
    logic [SUM_W-1:0]    pix_sum;
    logic [PW-1:0]       pend_base;
    logic                geom_write;

    // Clamp geometry writes into the supported range
    always_comb begin
        cfg_w     = cfg_wr_data[WIDTH_CFG_W-1:0];
        cfg_w_ext = XW'(cfg_w);
        if (cfg_w == '0) begin
            width_clamped = WW'(1);
        end else if (cfg_w_ext > XW'(MAX_WIDTH)) begin
            width_clamped = WW'(MAX_WIDTH);
        end else begin
            width_clamped = WW'(cfg_w);
        end
        cfg_h = cfg_wr_data[HEIGHT_W-1:0];
        if (cfg_h == '0) begin
            height_clamped = HEIGHT_W'(1);
        end else if (cfg_h > HEIGHT_W'(MAX_HEIGHT)) begin
            height_clamped = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            height_clamped = cfg_h;
        end
    end

    // Position of this transfer: the real pixel, or a virtual one past the
    // frame end while draining
    always_comb begin
        is_pix    = (in_data.op == OP_PIXEL);
        is_drain  = (in_data.op == OP_DRAIN);
        at_origin = (col_reg == '0) && (row_reg == '0);
        w_m1      = AW'(width_reg - WW'(1));
        w_plus1   = PW'(width_reg) + PW'(1);
        step      = WW'(w_plus1 - pend_reg);
        step_wrap = (step == width_reg);
        drain_ok  = is_drain && at_origin && (pend_reg != '0) && (pend_reg <= w_plus1);
        go        = is_pix || drain_ok;
        pix_sum   = SUM_W'(in_data.red) + SUM_W'(in_data.green) + SUM_W'(in_data.blue);

        if (is_pix) begin
            x_s = col_reg;
            y_s = HEIGHT_W'(row_reg);
        end else begin
            x_s = step_wrap ? '0 : AW'(step);
            y_s = height_reg + HEIGHT_W'(step_wrap);
        end

        // Column zero completes the last pixel of the row two back
        x_zero = (x_s == '0);
        emit   = x_zero ? (y_s >= HEIGHT_W'(2)) : (y_s >= HEIGHT_W'(1));
        qx     = x_zero ? w_m1 : x_s - AW'(1);
        qy     = x_zero ? y_s - HEIGHT_W'(2) : y_s - HEIGHT_W'(1);

        item_next.valid    = in_accept && go;
        item_next.emit     = emit;
        item_next.last     = is_drain && (pend_reg == PW'(1));
        item_next.column   = COL_W'(qx);
        item_next.row      = ROW_W'(qy);
        item_next.left_ok  = (qx != '0);
        item_next.right_ok = (WW'(qx) + WW'(1)) < width_reg;
        item_next.top_ok   = (qy != '0);
        item_next.bot_ok   = (qy + HEIGHT_W'(1)) < height_reg;
        item_next.sum      = is_pix ? pix_sum : '0;
    end

    always_comb begin
        geom_write = cfg_wr_en &&
                     ((cfg_addr == REG_IMAGE_WIDTH) || (cfg_addr == REG_IMAGE_HEIGHT));
        pend_base  = at_origin ? '0 : pend_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pend_next  = pend_reg;
        if (geom_write) begin
            col_next  = '0;
            row_next  = '0;
            pend_next = '0;
        end else if (in_accept && is_pix) begin
            pend_next = emit ? pend_base : pend_base + PW'(1);
            if (col_reg == w_m1) begin
                col_next = '0;
                if ((HEIGHT_W'(row_reg) + HEIGHT_W'(1)) >= height_reg) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + ROW_W'(1);
                end
            end else begin
                col_next = col_reg + AW'(1);
            end
        end else if (in_accept && drain_ok && emit) begin
            pend_next = pend_reg - PW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WW'(RESET_W);
            height_reg <= HEIGHT_W'(RESET_HEIGHT);
            thresh_reg <= THRESH_W'(RESET_THRESHOLD);
            col_reg    <= '0;
            row_reg    <= '0;
            pend_reg   <= '0;
            item_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_IMAGE_WIDTH:        width_reg  <= width_clamped;
                    REG_IMAGE_HEIGHT:       height_reg <= height_clamped;
                    REG_CONTRAST_THRESHOLD: thresh_reg <= cfg_wr_data[THRESH_W-1:0];
                    default: ;
                endcase
            end
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
            if (advance) begin
                item_reg <= item_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            addr_reg <= x_s;
        end
    end

    assign rd_en     = in_accept && go;
    assign rd_addr   = x_s;
    assign item      = item_reg;
    assign item_addr = addr_reg;
    assign threshold = thresh_reg;

endmodule

>>> rtl/core/pwcd_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcd_window
// Sliding window of sums, masked neighbor differences, maximum tree and the
// result register.
// ----------------------------------------------------------------------------
module pwcd_window
    import pwcd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  pwcd_item_t          item,
    input  logic [SUM_W-1:0]    rd_older,
    input  logic [SUM_W-1:0]    rd_newer,
    input  logic [THRESH_W-1:0] threshold,
    output logic                wr_en,
    output logic [SUM_W-1:0]    wr_older,
    output logic [SUM_W-1:0]    wr_newer,
    output logic                m_valid,
    output pwcd_out_t           m_data
);

    // Two window columns are kept; the third is the one arriving now
    logic [SUM_W-1:0] left_col_reg [3];
    logic [SUM_W-1:0] mid_col_reg  [3];
    logic [SUM_W-1:0] right_col    [3];
    logic [SUM_W-1:0] center;

    logic [SUM_W-1:0] diff_next [NUM_TAPS];
    logic [SUM_W-1:0] diff_reg  [NUM_TAPS];
    logic             p2_valid_reg;
    logic [COL_W-1:0] p2_col_reg;
    logic [ROW_W-1:0] p2_row_reg;
    logic             p2_last_reg;

    logic [SUM_W-1:0] lvl1 [4];
    logic [SUM_W-1:0] lvl2 [2];
    logic [SUM_W-1:0] max_delta;
    pwcd_out_t        out_next;

    logic      m_valid_reg;
    pwcd_out_t m_data_reg;

    always_comb begin
        right_col[0] = rd_older;
        right_col[1] = rd_newer;
        right_col[2] = item.sum;
        center       = mid_col_reg[1];

        // Drop neighbors outside the frame
        diff_next[0] = (item.left_ok && item.top_ok) ? abs_diff(left_col_reg[0], center) : '0;
        diff_next[1] = item.left_ok ? abs_diff(left_col_reg[1], center) : '0;
        diff_next[2] = (item.left_ok && item.bot_ok) ? abs_diff(left_col_reg[2], center) : '0;
        diff_next[3] = item.top_ok ? abs_diff(mid_col_reg[0], center) : '0;
        diff_next[4] = item.bot_ok ? abs_diff(mid_col_reg[2], center) : '0;
        diff_next[5] = (item.right_ok && item.top_ok) ? abs_diff(right_col[0], center) : '0;
        diff_next[6] = item.right_ok ? abs_diff(right_col[1], center) : '0;
        diff_next[7] = (item.right_ok && item.bot_ok) ? abs_diff(right_col[2], center) : '0;
    end

    assign wr_en    = advance && item.valid;
    assign wr_older = rd_newer;
    assign wr_newer = item.sum;

    always_ff @(posedge aclk) begin
        if (advance && item.valid) begin
            for (int i = 0; i < 3; i++) begin
                left_col_reg[i] <= mid_col_reg[i];
                mid_col_reg[i]  <= right_col[i];
            end
        end
        if (advance) begin
            for (int i = 0; i < NUM_TAPS; i++) begin
                diff_reg[i] <= diff_next[i];
            end
            p2_col_reg  <= item.column;
            p2_row_reg  <= item.row;
            p2_last_reg <= item.last;
            m_data_reg  <= out_next;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            lvl1[i] = max2(diff_reg[2*i], diff_reg[2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
            lvl2[i] = max2(lvl1[2*i], lvl1[2*i+1]);
        end
        max_delta = max2(lvl2[0], lvl2[1]);

        out_next.column         = p2_col_reg;
        out_next.row            = p2_row_reg;
        out_next.max_delta      = max_delta;
        out_next.needs_resample = (max_delta > threshold);
        out_next.frame_end      = p2_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            p2_valid_reg <= item.valid && item.emit;
            m_valid_reg  <= p2_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/core/pixel_window_contrast_detector.sv
`timescale 1ns / 1ps
// Throughput: one transfer per clock; the pipeline stalls only while m_valid waits on m_ready.
// Result path: a pixel's result completes with the transfer one row plus one pixel later (or a
//   drain); m_valid rises after that transfer passes the item, window and result registers.
// Line store: one read and one write per cycle, with forwarding when back-to-back positions
//   share a column (one-pixel-wide frames, last drain followed by a new frame).
// Reset: synchronous, active low; clears position, pending count and pipeline valids and loads
//   the default geometry. Line memories are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// pixel_window_contrast_detector
// 3x3 contrast detector on R+G+B sums of a raster pixel stream, flagging
// pixels whose largest neighbor difference exceeds a threshold.
// ----------------------------------------------------------------------------
module pixel_window_contrast_detector
    import pwcd_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pwcd_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pwcd_out_t             m_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic                advance;
    logic                in_accept;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    pwcd_item_t          item;
    logic [AW-1:0]       item_addr;
    logic [THRESH_W-1:0] threshold;
    logic                wr_en;
    logic [SUM_W-1:0]    wr_older;
    logic [SUM_W-1:0]    wr_newer;
    logic [SUM_W-1:0]    rd_older;
    logic [SUM_W-1:0]    rd_newer;

    // Advance the whole pipeline whenever the result register can take data
    assign advance   = !m_valid || m_ready;
    assign s_ready   = advance;
    assign in_accept = s_valid && s_ready;

    pwcd_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .in_accept   (in_accept),
        .in_data     (s_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .item        (item),
        .item_addr   (item_addr),
        .threshold   (threshold)
    );

    pwcd_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (item_addr),
        .wr_older (wr_older),
        .wr_newer (wr_newer),
        .rd_older (rd_older),
        .rd_newer (rd_newer)
    );

    pwcd_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (item),
        .rd_older  (rd_older),
        .rd_newer  (rd_newer),
        .threshold (threshold),
        .wr_en     (wr_en),
        .wr_older  (wr_older),
        .wr_newer  (wr_newer),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

>>> rtl/core/pwcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcd_checker
// Port-level checks of the contrast detector, bound to the top level.
// ----------------------------------------------------------------------------
module pwcd_checker
    import pwcd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input pwcd_out_t m_data
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Input side takes a transfer exactly when the result register can advance
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow result register state");

    a_delta_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.max_delta <= SUM_W'(MAX_DELTA)))
        else $error("max_delta exceeds largest possible sum difference");

endmodule

bind pixel_window_contrast_detector pwcd_checker u_pwcd_checker (.*);

>>> tb/sv/pixel_window_contrast_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_window_contrast_detector_tb
// Streams RGB frames of varied geometry and threshold through the detector.
// Source and sink idle at random in several phases. A bit-accurate window
// predictor runs on every accepted transfer, and each result is compared
// field by field with the oldest expected window result.
// ----------------------------------------------------------------------------
module pixel_window_contrast_detector_tb;
    import pwcd_pkg::*;

    localparam int LINE_DEPTH    = 1024;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    pwcd_in_t              s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    pwcd_out_t             m_data;

    pixel_window_contrast_detector dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // Predictor state
    logic [WIDTH_CFG_W-1:0] width_reg;
    logic [HEIGHT_W-1:0]    height_reg;
    logic [THRESH_W-1:0]    threshold_reg;
    logic [SUM_W-1:0]       older_sums [LINE_DEPTH];
    logic [SUM_W-1:0]       newer_sums [LINE_DEPTH];
    logic [SUM_W-1:0]       window_taps [9];
    int                     col_pos;
    int                     row_pos;
    int                     pending_results;
    pwcd_out_t              expected_contrast [$];

    int errors          = 0;
    int items_sent      = 0;
    int cycle_count     = 0;
    int source_idle_pct = 0;
    int sink_stall_pct  = 0;
    int hold_token      = 0;
    int hold_seen       = 0;
    int hold_left       = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sink: random stalls, plus a long hold-off whenever the token moves
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic void reset_predictor();
        width_reg       = WIDTH_CFG_W'(RESET_WIDTH);
        height_reg      = HEIGHT_W'(RESET_HEIGHT);
        threshold_reg   = THRESH_W'(RESET_THRESHOLD);
        col_pos         = 0;
        row_pos         = 0;
        pending_results = 0;
        for (int i = 0; i < LINE_DEPTH; i++) begin
            older_sums[i] = '0;
            newer_sums[i] = '0;
        end
        for (int i = 0; i < 9; i++) window_taps[i] = '0;
    endfunction

    function automatic int active_width();
        int w;
        w = int'(width_reg);
        if (w < 1) w = 1;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        return w;
    endfunction

    function automatic int active_height();
        int h;
        h = int'(height_reg);
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    // Largest |sum difference| around window column cpos, which holds pixel (qx, qy);
    // neighbors outside the frame are skipped.
    function automatic int window_max_delta(input int cpos, input int qx, input int qy,
                                            input int w, input int h);
        int dc, dr, nx, ny, pos, v, center, d, best;
        center = int'(window_taps[cpos * 3 + 1]);
        best   = 0;
        for (dc = -1; dc <= 1; dc++) begin
            for (dr = -1; dr <= 1; dr++) begin
                nx  = qx + dc;
                ny  = qy + dr;
                pos = cpos + dc;
                if (nx >= 0 && nx < w && ny >= 0 && ny < h && pos >= 0 && pos <= 2) begin
                    v = int'(window_taps[pos * 3 + 1 + dr]);
                    d = (v > center) ? v - center : center - v;
                    if (d > best) best = d;
                end
            end
        end
        return best;
    endfunction

    // Shift one position (real or virtual) into the window; report the pixel that completes
    function automatic bit advance_window(input int x, input int y, input logic [SUM_W-1:0] sum,
                                          output int qx, output int qy, output int delta);
        int w, h, idx;
        bit emit;
        w     = active_width();
        h     = active_height();
        idx   = x % LINE_DEPTH;
        emit  = 1'b0;
        qx    = 0;
        qy    = 0;
        delta = 0;
        // Row wrap: the last pixel two rows up completes in the rightmost window column
        if (x == 0 && y >= 2) begin
            qx    = w - 1;
            qy    = y - 2;
            delta = window_max_delta(2, w - 1, y - 2, w, h);
            emit  = 1'b1;
        end
        for (int i = 0; i < 6; i++) window_taps[i] = window_taps[i + 3];
        window_taps[6]  = older_sums[idx];
        window_taps[7]  = newer_sums[idx];
        window_taps[8]  = sum;
        older_sums[idx] = newer_sums[idx];
        newer_sums[idx] = sum;
        if (x >= 1 && y >= 1) begin
            qx    = x - 1;
            qy    = y - 1;
            delta = window_max_delta(1, x - 1, y - 1, w, h);
            emit  = 1'b1;
        end
        return emit;
    endfunction

    function automatic void predict_contrast(input pwcd_in_t item);
        int w, h, qx, qy, delta, k, step;
        logic [SUM_W-1:0] sum;
        bit emit, last;
        pwcd_out_t res;
        w    = active_width();
        h    = active_height();
        last = 1'b0;
        if (item.op == OP_PIXEL) begin
            sum = SUM_W'(item.red) + SUM_W'(item.green) + SUM_W'(item.blue);
            if (col_pos >= w) col_pos = w - 1;
            if (row_pos >= h) row_pos = h - 1;
            // First pixel of a frame drops whatever the last frame left undrained
            if (col_pos == 0 && row_pos == 0) pending_results = 0;
            emit = advance_window(col_pos, row_pos, sum, qx, qy, delta);
            if (!emit) pending_results++;
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h) row_pos = 0;
            end
        end else begin
            k = pending_results;
            if (col_pos != 0 || row_pos != 0 || k == 0 || k > w + 1) return;
            step = w + 1 - k;
            emit = advance_window(step % w, h + step / w, '0, qx, qy, delta);
            if (!emit) return;
            pending_results--;
            last = (k == 1);
        end
        if (emit) begin
            res.column         = qx[COL_W-1:0];
            res.row            = qy[ROW_W-1:0];
            res.max_delta      = delta[SUM_W-1:0];
            res.needs_resample = (delta > int'(threshold_reg));
            res.frame_end      = last;
            expected_contrast.push_back(res);
        end
    endfunction

    function automatic void apply_register_write(input logic [CFG_ADDR_W-1:0] idx,
                                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_IMAGE_WIDTH: begin
                width_reg       = data[WIDTH_CFG_W-1:0];
                col_pos         = 0;
                row_pos         = 0;
                pending_results = 0;
            end
            REG_IMAGE_HEIGHT: begin
                height_reg      = data[HEIGHT_W-1:0];
                col_pos         = 0;
                row_pos         = 0;
                pending_results = 0;
            end
            REG_CONTRAST_THRESHOLD: begin
                threshold_reg = data[THRESH_W-1:0];
            end
            default: ;
        endcase
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_contrast(input pwcd_out_t got);
        pwcd_out_t want;
        if (expected_contrast.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual column %0d row %0d delta %0d",
                     $time, got.column, got.row, got.max_delta);
            errors++;
            return;
        end
        want = expected_contrast.pop_front();
        compare_field("column", int'(want.column), int'(got.column));
        compare_field("row", int'(want.row), int'(got.row));
        compare_field("max_delta", int'(want.max_delta), int'(got.max_delta));
        compare_field("needs_resample", int'(want.needs_resample), int'(got.needs_resample));
        compare_field("frame_end", int'(want.frame_end), int'(got.frame_end));
    endfunction

    // Check results first: nothing accepted at this edge can have a result yet
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) check_contrast(m_data);
            if (cfg_wr_en) apply_register_write(cfg_addr, cfg_wr_data);
            if (s_valid && s_ready) predict_contrast(s_data);
        end
    end

    function automatic pwcd_in_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        pwcd_in_t p;
        p.op    = OP_PIXEL;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        return p;
    endfunction

    function automatic pwcd_in_t random_pixel();
        pwcd_in_t p;
        // Mix saturated colors in for large deltas
        if ($urandom_range(3) == 0) begin
            p = make_pixel($urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
                           $urandom_range(1) ? 8'hFF : 8'h00);
        end else begin
            p = make_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)));
        end
        return p;
    endfunction

    function automatic pwcd_in_t drain_item();
        pwcd_in_t p;
        p    = make_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
        p.op = OP_DRAIN;
        return p;
    endfunction

    function automatic int random_threshold();
        case ($urandom_range(9))
            0:       return 0;
            1:       return MAX_DELTA;
            2:       return 1023;
            default: return $urandom_range(MAX_DELTA);
        endcase
    endfunction

    // Leave valid high on return: the next transfer may follow in the same step
    task automatic send_item(input pwcd_in_t item);
        while ($urandom_range(99) < source_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_contrast.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_geometry(input int w, input int h, input int thr);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_CONTRAST_THRESHOLD, thr);
    endtask

    // Send pixels with a few stray drains mixed in, then optionally flush the frame
    task automatic run_frame(input int w, input int pixels, input bit flush);
        for (int i = 0; i < pixels; i++) begin
            if (i != 0 && $urandom_range(99) < 4) send_item(drain_item());
            send_item(random_pixel());
        end
        if (flush) repeat (w + 1 + $urandom_range(1)) send_item(drain_item());
    endtask

    task automatic test_directed();
        source_idle_pct = 0;
        sink_stall_pct <= 0;
        send_item(drain_item());
        set_geometry(3, 2, 100);
        send_item(make_pixel(8'hFF, 8'hFF, 8'hFF));
        send_item(make_pixel(8'h00, 8'h00, 8'h00));
        send_item(drain_item());
        send_item(make_pixel(8'hFF, 8'h00, 8'h00));
        send_item(make_pixel(8'h00, 8'hFF, 8'h00));
        send_item(make_pixel(8'h00, 8'h00, 8'hFF));
        send_item(make_pixel(8'h80, 8'h7F, 8'h01));
        // Four drains flush the frame, the fifth finds nothing pending
        repeat (5) send_item(drain_item());
        set_geometry(2, 2, MAX_DELTA);
        send_item(make_pixel(8'hFF, 8'hFF, 8'hFF));
        send_item(make_pixel(8'h00, 8'h00, 8'h00));
        send_item(make_pixel(8'h00, 8'h00, 8'h00));
        send_item(make_pixel(8'hFF, 8'hFF, 8'hFF));
        repeat (3) send_item(drain_item());
    endtask

    task automatic test_clamped_geometry();
        source_idle_pct = 0;
        sink_stall_pct <= 0;
        set_geometry(0, 0, 0);
        repeat (3) run_frame(1, 1, 1'b1);
        set_geometry(1, 5, 10);
        run_frame(1, 5, 1'b1);
        wait_idle();
        // Bits above the register width are dropped: width 5
        write_reg(REG_IMAGE_WIDTH, 13'h0805);
        write_reg(REG_UNUSED, 13'h1FFF);
        run_frame(5, 5, 1'b1);
        wait_idle();
        write_reg(REG_CONTRAST_THRESHOLD, 13'h1FFF);
        run_frame(5, 5, 1'b1);
    endtask

    task automatic test_random_frames(input int src_pct, input int sink_pct, input int quota);
        int w, h, ew, eh, first;
        source_idle_pct = src_pct;
        sink_stall_pct <= sink_pct;
        first = items_sent;
        while (items_sent - first < quota) begin
            case ($urandom_range(9))
                0:       w = 0;
                1:       w = 1;
                2:       w = 2;
                default: w = $urandom_range(3, 12);
            endcase
            case ($urandom_range(7))
                0:       h = 0;
                1:       h = 1;
                default: h = $urandom_range(2, 6);
            endcase
            set_geometry(w, h, random_threshold());
            ew = (w == 0) ? 1 : w;
            eh = (h == 0) ? 1 : h;
            case ($urandom_range(9))
                // Cut short: the next geometry write drops the undrained results
                0: run_frame(ew, $urandom_range(1, ew * eh), 1'b0);
                // Back to back: the second frame discards the first one's tail
                1: begin
                    run_frame(ew, ew * eh, 1'b0);
                    run_frame(ew, ew * eh, 1'b1);
                end
                default: run_frame(ew, ew * eh, 1'b1);
            endcase
        end
    endtask

    task automatic test_output_backpressure();
        source_idle_pct = 0;
        sink_stall_pct <= 0;
        set_geometry(8, 8, 40);
        hold_token <= hold_token + 1;
        run_frame(8, 64, 1'b1);
    endtask

    initial begin
        reset_predictor();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_clamped_geometry();
        test_random_frames(0, 0, 170);
        test_random_frames(68, 0, 170);
        test_random_frames(0, 68, 170);
        test_random_frames(6, 6, 170);
        test_output_backpressure();
        wait_idle();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
